// File: design/arfp_pkg.sv
// Shared constants for the ASCII reply field parser.
`timescale 1ns / 1ps

package arfp_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_FIELDS_DEF = 3;

    localparam int VAL_OUT_W = 32;
    localparam int FIDX_W    = 3;
    localparam int PH_W      = 3;
    localparam int KIND_W    = 2;
    localparam int ST_W      = 3;

    localparam logic [PH_W-1:0] PH_START   = 3'd0;
    localparam logic [PH_W-1:0] PH_C_SEEN  = 3'd1;
    localparam logic [PH_W-1:0] PH_V_SEEN  = 3'd2;
    localparam logic [PH_W-1:0] PH_CR_SEEN = 3'd3;
    localparam logic [PH_W-1:0] PH_FIELDS  = 3'd4;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VOLT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ENC  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_PREFIX    = 3'd1;
    localparam logic [ST_W-1:0] ST_MALFORMED = 3'd2;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [ST_W-1:0] ST_COUNT     = 3'd4;

    localparam logic [FIDX_W-1:0] VOLT_COUNT = 3'd3;
    localparam logic [FIDX_W-1:0] ENC_COUNT  = 3'd2;

    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

endpackage

// File: design/arfp_digit_acc.sv
// Decimal digit accumulate with signed range check.
`timescale 1ns / 1ps

module arfp_digit_acc #(
    parameter int VALUE_BITS = arfp_pkg::VALUE_BITS_DEF
) (
    input  logic [VALUE_BITS-1:0] i_mag,
    input  logic                  i_neg,
    input  logic [3:0]            i_digit,
    output logic [VALUE_BITS-1:0] o_mag,
    output logic                  o_ovf
);
    import arfp_pkg::*;

    localparam int WIDE_W = VALUE_BITS + 4;

    logic [WIDE_W-1:0] w_wide;
    logic [WIDE_W-1:0] w_limit;

    assign w_wide  = (WIDE_W'(i_mag) << 3) + (WIDE_W'(i_mag) << 1) + WIDE_W'(i_digit);
    assign w_limit = (WIDE_W'(1) << (VALUE_BITS - 1)) - WIDE_W'(!i_neg);
    assign o_ovf   = w_wide > w_limit;
    assign o_mag   = w_wide[VALUE_BITS-1:0];

endmodule

// File: design/ascii_reply_field_parser.sv
// Top level of the ASCII reply field parser.
// Usage: feed one reply byte per request on the input channel (i_valid,
// o_stall, i_byte_req, i_last); i_last marks the final byte of a reply.
// Replies start with "V=" (three fields) or "CR=" (two fields), followed by
// colon-separated signed decimal integers and optional CR/LF trailer bytes.
// Only the final byte of a reply produces a result request on the output
// channel (o_valid, i_stall): kind, status and three 32-bit values.
// Values are zero unless the status is ok.
// The result register is loaded when the final byte is taken.
// Throughput: one byte per cycle while o_stall is low; each byte passes
// through compare and x10 accumulate logic ahead of the result register.
// A held result blocks new bytes only while i_stall is high; the output
// register drains in the same cycle that a new result is loaded.
// Reset (synchronous, i_rst_n low) drops any pending result and returns the
// parser to the start of a reply.
`timescale 1ns / 1ps

module ascii_reply_field_parser #(
    parameter int VALUE_BITS = arfp_pkg::VALUE_BITS_DEF,
    parameter int MAX_FIELDS = arfp_pkg::MAX_FIELDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_byte_req,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [arfp_pkg::KIND_W-1:0]         o_kind,
    output logic [arfp_pkg::ST_W-1:0]           o_status,
    output logic signed [arfp_pkg::VAL_OUT_W-1:0] o_value0,
    output logic signed [arfp_pkg::VAL_OUT_W-1:0] o_value1,
    output logic signed [arfp_pkg::VAL_OUT_W-1:0] o_value2
);
    import arfp_pkg::*;

    logic [PH_W-1:0]   r_phase, n_phase;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [FIDX_W-1:0] r_idx, n_idx;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic              r_neg, n_neg;
    logic              r_digit, n_digit;
    logic              r_trail, n_trail;
    logic [ST_W-1:0]   r_err, n_err;
    logic [MAX_FIELDS-1:0][VAL_OUT_W-1:0] r_vals, n_vals;
    logic [MAX_FIELDS-1:0][VAL_OUT_W-1:0] v_vals;

    logic              r_out_valid;
    logic [KIND_W-1:0] r_out_kind, n_out_kind;
    logic [ST_W-1:0]   r_out_status, n_out_status;
    logic [2:0][VAL_OUT_W-1:0] r_out_vals, n_out_vals;
    logic [2:0][VAL_OUT_W-1:0] w_fin_vals;

    logic              w_accept;
    logic              w_eol;
    logic              w_is_digit;
    logic [VALUE_BITS-1:0] w_acc_mag;
    logic              w_acc_ovf;
    logic [FIDX_W-1:0] v_expect;
    logic signed [VALUE_BITS-1:0] v_fval;

    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;
    assign w_eol    = (i_byte_req == CH_CR) || (i_byte_req == CH_LF);
    assign w_is_digit = (i_byte_req >= CH_0) && (i_byte_req <= CH_9);

    arfp_digit_acc #(
        .VALUE_BITS (VALUE_BITS)
    ) u_digit_acc (
        .i_mag   (r_mag),
        .i_neg   (r_neg),
        .i_digit (i_byte_req[3:0]),
        .o_mag   (w_acc_mag),
        .o_ovf   (w_acc_ovf)
    );

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_idx   = r_idx;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_digit = r_digit;
        n_trail = r_trail;
        n_err   = r_err;
        n_vals  = r_vals;
        v_vals  = r_vals;
        v_expect = ENC_COUNT;
        v_fval   = '0;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;

        if (w_accept) begin
            if (r_err == ST_OK) begin
                case (r_phase)
                    PH_START: begin
                        if (i_byte_req == CH_V) begin
                            n_phase = PH_V_SEEN;
                        end else if (i_byte_req == CH_C) begin
                            n_phase = PH_C_SEEN;
                        end else begin
                            n_err = ST_PREFIX;
                        end
                    end
                    PH_C_SEEN: begin
                        if (i_byte_req == CH_R) begin
                            n_phase = PH_CR_SEEN;
                        end else begin
                            n_err = ST_PREFIX;
                        end
                    end
                    PH_V_SEEN: begin
                        if (i_byte_req == CH_EQ) begin
                            n_kind  = KIND_VOLT;
                            n_phase = PH_FIELDS;
                        end else begin
                            n_err = ST_PREFIX;
                        end
                    end
                    PH_CR_SEEN: begin
                        if (i_byte_req == CH_EQ) begin
                            n_kind  = KIND_ENC;
                            n_phase = PH_FIELDS;
                        end else begin
                            n_err = ST_PREFIX;
                        end
                    end
                    default: begin
                        v_expect = (r_kind == KIND_VOLT) ? VOLT_COUNT : ENC_COUNT;
                        if (r_trail) begin
                            if (!w_eol) begin
                                n_err = ST_MALFORMED;
                            end
                        end else if (w_eol) begin
                            n_trail = 1'b1;
                        end else if (i_byte_req == CH_COLON) begin
                            // close the field on a separator
                            if (!r_digit) begin
                                n_err = ST_MALFORMED;
                            end else begin
                                v_fval = r_neg ? (~r_mag + 1'b1) : r_mag;
                                for (int k = 0; k < MAX_FIELDS; k++) begin
                                    if (r_idx == FIDX_W'(k)) begin
                                        n_vals[k] = VAL_OUT_W'(v_fval);
                                    end
                                end
                                if (r_idx <= v_expect) begin
                                    n_idx = r_idx + 1'b1;
                                end
                                n_mag   = '0;
                                n_neg   = 1'b0;
                                n_digit = 1'b0;
                            end
                        end else if (i_byte_req == CH_MINUS) begin
                            if (r_digit || r_neg) begin
                                n_err = ST_MALFORMED;
                            end else begin
                                n_neg = 1'b1;
                            end
                        end else if (w_is_digit) begin
                            if (w_acc_ovf) begin
                                n_err = ST_OVERFLOW;
                            end else begin
                                n_mag   = w_acc_mag;
                                n_digit = 1'b1;
                            end
                        end else begin
                            n_err = ST_MALFORMED;
                        end
                    end
                endcase
            end

            if (i_last) begin
                v_expect = (n_kind == KIND_VOLT) ? VOLT_COUNT : ENC_COUNT;
                if (n_err == ST_OK) begin
                    if (n_phase != PH_FIELDS) begin
                        n_err = ST_PREFIX;
                    end else if (!n_digit) begin
                        n_err = ST_MALFORMED;
                    end else begin
                        // close the final field
                        v_fval = n_neg ? (~n_mag + 1'b1) : n_mag;
                        for (int k = 0; k < MAX_FIELDS; k++) begin
                            if (n_idx == FIDX_W'(k)) begin
                                n_vals[k] = VAL_OUT_W'(v_fval);
                            end
                        end
                        if (n_idx <= v_expect) begin
                            n_idx = n_idx + 1'b1;
                        end
                    end
                end
                if (n_err == ST_OK && n_idx != v_expect) begin
                    n_err = ST_COUNT;
                end

                n_out_kind   = n_kind;
                n_out_status = n_err;
                v_vals       = n_vals;

                n_phase = PH_START;
                n_kind  = KIND_NONE;
                n_idx   = '0;
                n_mag   = '0;
                n_neg   = 1'b0;
                n_digit = 1'b0;
                n_trail = 1'b0;
                n_err   = ST_OK;
                n_vals  = '0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_fin
            if (g < MAX_FIELDS) begin : g_have
                assign w_fin_vals[g] = v_vals[g];
            end else begin : g_none
                assign w_fin_vals[g] = '0;
            end
        end
    endgenerate

    always_comb begin
        n_out_vals = r_out_vals;
        if (w_accept && i_last) begin
            n_out_vals = '0;
            if (n_out_status == ST_OK) begin
                n_out_vals = w_fin_vals;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_kind      <= KIND_NONE;
            r_idx       <= '0;
            r_mag       <= '0;
            r_neg       <= 1'b0;
            r_digit     <= 1'b0;
            r_trail     <= 1'b0;
            r_err       <= ST_OK;
            r_vals      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_idx   <= n_idx;
            r_mag   <= n_mag;
            r_neg   <= n_neg;
            r_digit <= n_digit;
            r_trail <= n_trail;
            r_err   <= n_err;
            r_vals  <= n_vals;
            if (w_accept && i_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_vals   <= n_out_vals;
    end

    assign o_valid  = r_out_valid;
    assign o_kind   = r_out_kind;
    assign o_status = r_out_status;
    assign o_value0 = r_out_vals[0];
    assign o_value1 = r_out_vals[1];
    assign o_value2 = r_out_vals[2];

endmodule
